FILE: rtl/core/mids_pkg.sv
package mids_pkg;

   // window geometry
   localparam int SIZE  = 1024;
   localparam int IDX_W = $clog2(SIZE);
   localparam int CNT_W = $clog2(SIZE + 1);
   localparam int ID_W  = 64;

   typedef logic [ID_W-1:0]  id_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [2:0]       cell_type;
   typedef logic [2:0]       status_type;
   typedef logic [1:0]       cmd_type;

   localparam idx_type LAST_IDX = idx_type'(SIZE - 1);

   // cell states
   localparam cell_type CELL_UNSEEN    = 3'd0;
   localparam cell_type CELL_RECEIVED  = 3'd1;
   localparam cell_type CELL_STARTED   = 3'd2;
   localparam cell_type CELL_CANCELLED = 3'd3;
   localparam cell_type CELL_DONE      = 3'd4;
   localparam cell_type CELL_ASYNC     = 3'd5;

   // result status codes
   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_TOO_LOW      = 3'd1;
   localparam status_type ST_TOO_HIGH     = 3'd2;
   localparam status_type ST_REUSED       = 3'd3;
   localparam status_type ST_OUTSIDE      = 3'd4;
   localparam status_type ST_UNEXPECTED   = 3'd5;
   localparam status_type ST_CANCEL_EARLY = 3'd6;

   // commands
   localparam cmd_type CMD_NEW    = 2'd0;
   localparam cmd_type CMD_START  = 2'd1;
   localparam cmd_type CMD_DONE   = 2'd2;
   localparam cmd_type CMD_CANCEL = 2'd3;

   // window compare results for the item in work
   typedef struct packed {
      logic    too_low;
      logic    all_ones;
      logic    advance;
      logic    short_jump;
      logic    in_win;
      idx_type top_idx;
   } win_flags_type;

   function automatic logic cell_active(input cell_type c);
      return (c == CELL_RECEIVED) || (c == CELL_STARTED) || (c == CELL_CANCELLED);
   endfunction

endpackage

FILE: rtl/core/mids_ram.sv
module mids_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 3
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mids_window.sv
module mids_window (
   input  logic                    clock,
   input  logic                    reset,
   input  mids_pkg::id_type        message_id,
   input  logic                    eval,
   input  logic                    commit,
   output mids_pkg::win_flags_type flags
);

   mids_pkg::id_type        top_ff;
   mids_pkg::id_type        top_in;
   mids_pkg::id_type        low;
   mids_pkg::id_type        diff;
   mids_pkg::win_flags_type flags_ff;
   mids_pkg::win_flags_type flags_in;

   // oldest id in the window and distance above the top
   assign low  = top_ff - mids_pkg::id_type'(mids_pkg::SIZE);
   assign diff = message_id - top_ff;

   always_comb begin
      flags_in.too_low    = message_id < low;
      flags_in.all_ones   = &message_id;
      flags_in.advance    = message_id >= top_ff;
      // jump id + 1 - top below SIZE
      flags_in.short_jump = diff < mids_pkg::id_type'(mids_pkg::SIZE - 1);
      flags_in.in_win     = (message_id >= low) && (message_id < top_ff);
      flags_in.top_idx    = top_ff[mids_pkg::IDX_W-1:0];
   end

   assign top_in = commit ? (message_id + mids_pkg::id_type'(1)) : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= mids_pkg::id_type'(mids_pkg::SIZE);
      end else begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eval) begin
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

FILE: rtl/core/message_id_window_scoreboard.sv
// message id window scoreboard
// tracks message ids in a window of SIZE ids below window_top; each id owns a
// 3-bit cell in a single-port-write, one-read RAM at index id mod SIZE
// request channel: req_valid/req_stall with req_cmd (new, start, done, cancel),
// req_message_id and req_went_async; an item is taken when valid and not stall
// result channel: rsp_valid/rsp_stall with rsp_status, rsp_flag and
// rsp_prior_state, exactly one result per request item, in order
// start, done, cancel and a new id inside the window go from accept to rsp_valid
// through decode and RAM read, modify and write, and result
// a new id above the top by a jump (id + 1 - window_top) below SIZE walks the vacated
// cells one per cycle; a blocked walk ends early
// a jump of SIZE or more clears the whole RAM if no cell is active, else it is too high
// only one item is in work at a time; req_stall is low only when idle, so a new
// item is taken only once the previous result is loaded into the output register
// reset: window_top returns to SIZE and a clearing pass writes every cell,
// cell 0 as done; req_stall stays high meanwhile
// a stalled result holds in the output register; the next item is still
// taken, and finishes only once the previous result has left
module message_id_window_scoreboard (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [63:0]          req_message_id,
   input  logic                 req_went_async,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic                 rsp_flag,
   output logic [2:0]           rsp_prior_state
);

   // sequencer states
   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_EXEC   = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   // captured item
   mids_pkg::cmd_type cmd_ff, cmd_in;
   mids_pkg::id_type  id_ff, id_in;
   logic              async_ff, async_in;
   mids_pkg::idx_type id_idx;

   // walk and clear pointers
   mids_pkg::idx_type rd_idx_ff, rd_idx_in;
   mids_pkg::idx_type chk_idx_ff, chk_idx_in;
   logic              chk_vld_ff, chk_vld_in;
   mids_pkg::idx_type clr_idx_ff, clr_idx_in;

   // number of cells in received, started or cancelled
   mids_pkg::cnt_type act_cnt_ff, act_cnt_in;

   // pending result
   mids_pkg::status_type res_status_ff, res_status_in;
   logic                 res_flag_ff, res_flag_in;
   mids_pkg::cell_type   res_prior_ff, res_prior_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   mids_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_flag_ff, rsp_flag_in;
   mids_pkg::cell_type   rsp_prior_ff, rsp_prior_in;

   // ram port
   logic               wr_en;
   mids_pkg::idx_type  wr_addr;
   mids_pkg::cell_type wr_data;
   mids_pkg::idx_type  rd_addr;
   mids_pkg::cell_type rd_data;

   // window
   logic                    eval;
   logic                    commit;
   mids_pkg::win_flags_type flags;

   mids_ram #(
      .DEPTH(mids_pkg::SIZE),
      .WIDTH(3)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mids_window u_window (
      .clock     (clock),
      .reset     (reset),
      .message_id(id_ff),
      .eval      (eval),
      .commit    (commit),
      .flags     (flags)
   );

   assign id_idx    = id_ff[mids_pkg::IDX_W-1:0];
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      async_in      = async_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      clr_idx_in    = clr_idx_ff;
      act_cnt_in    = act_cnt_ff;
      res_status_in = res_status_ff;
      res_flag_in   = res_flag_ff;
      res_prior_in  = res_prior_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_prior_in  = rsp_prior_ff;
      wr_en         = 1'b0;
      wr_addr       = id_idx;
      wr_data       = mids_pkg::CELL_UNSEEN;
      rd_addr       = id_idx;
      eval          = 1'b0;
      commit        = 1'b0;

      case (state_ff)
         S_INIT: begin
            // power-up clearing pass, cell 0 starts as done
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = (clr_idx_ff == '0) ? mids_pkg::CELL_DONE : mids_pkg::CELL_UNSEEN;
            clr_idx_in = clr_idx_ff + mids_pkg::idx_type'(1);
            act_cnt_in = '0;
            if (clr_idx_ff == mids_pkg::LAST_IDX) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               id_in    = req_message_id;
               async_in = req_went_async;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            // window compares and target read in parallel
            eval     = 1'b1;
            rd_addr  = id_idx;
            state_in = S_EXEC;
         end

         S_EXEC: begin
            res_status_in = mids_pkg::ST_OK;
            res_flag_in   = 1'b0;
            res_prior_in  = mids_pkg::CELL_UNSEEN;
            state_in      = S_RESP;
            if (cmd_ff == mids_pkg::CMD_NEW) begin
               if (flags.too_low) begin
                  res_status_in = mids_pkg::ST_TOO_LOW;
               end else if (flags.all_ones) begin
                  res_status_in = mids_pkg::ST_TOO_HIGH;
               end else if (flags.advance) begin
                  if (flags.short_jump) begin
                     // walk vacated cells from the old top
                     rd_idx_in  = flags.top_idx;
                     chk_vld_in = 1'b0;
                     state_in   = S_WALK;
                  end else if (act_cnt_ff != '0) begin
                     res_status_in = mids_pkg::ST_TOO_HIGH;
                  end else begin
                     clr_idx_in = '0;
                     state_in   = S_CLEAR;
                  end
               end else begin
                  res_prior_in = rd_data;
                  if (rd_data != mids_pkg::CELL_UNSEEN) begin
                     res_status_in = mids_pkg::ST_REUSED;
                  end else begin
                     wr_en      = 1'b1;
                     wr_data    = mids_pkg::CELL_RECEIVED;
                     act_cnt_in = act_cnt_ff + mids_pkg::cnt_type'(1);
                  end
               end
            end else if (!flags.in_win) begin
               res_status_in = mids_pkg::ST_OUTSIDE;
            end else begin
               res_prior_in = rd_data;
               case (cmd_ff)
                  mids_pkg::CMD_START: begin
                     if (rd_data == mids_pkg::CELL_RECEIVED) begin
                        wr_en   = 1'b1;
                        wr_data = mids_pkg::CELL_STARTED;
                     end else if (rd_data == mids_pkg::CELL_CANCELLED) begin
                        res_flag_in = 1'b1;
                     end else begin
                        res_status_in = mids_pkg::ST_UNEXPECTED;
                     end
                  end
                  mids_pkg::CMD_DONE: begin
                     if ((rd_data != mids_pkg::CELL_STARTED) &&
                         (rd_data != mids_pkg::CELL_CANCELLED)) begin
                        res_status_in = mids_pkg::ST_UNEXPECTED;
                     end
                     wr_en   = 1'b1;
                     wr_data = async_ff ? mids_pkg::CELL_ASYNC : mids_pkg::CELL_DONE;
                     if (mids_pkg::cell_active(rd_data)) begin
                        act_cnt_in = act_cnt_ff - mids_pkg::cnt_type'(1);
                     end
                  end
                  mids_pkg::CMD_CANCEL: begin
                     if (rd_data == mids_pkg::CELL_UNSEEN) begin
                        res_status_in = mids_pkg::ST_CANCEL_EARLY;
                     end else if (rd_data == mids_pkg::CELL_RECEIVED) begin
                        wr_en   = 1'b1;
                        wr_data = mids_pkg::CELL_CANCELLED;
                     end else if (rd_data == mids_pkg::CELL_STARTED) begin
                        wr_en       = 1'b1;
                        wr_data     = mids_pkg::CELL_CANCELLED;
                        res_flag_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            // read one cell ahead, check and clear the one read last cycle
            rd_addr    = rd_idx_ff;
            rd_idx_in  = rd_idx_ff + mids_pkg::idx_type'(1);
            chk_idx_in = rd_idx_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               wr_addr = chk_idx_ff;
               if (mids_pkg::cell_active(rd_data)) begin
                  // blocked: cleared cells stay cleared, top unchanged
                  res_status_in = mids_pkg::ST_TOO_HIGH;
                  res_prior_in  = mids_pkg::CELL_UNSEEN;
                  state_in      = S_RESP;
               end else if (chk_idx_ff == id_idx) begin
                  // last vacated cell is the target itself
                  wr_en         = 1'b1;
                  wr_data       = mids_pkg::CELL_RECEIVED;
                  act_cnt_in    = act_cnt_ff + mids_pkg::cnt_type'(1);
                  commit        = 1'b1;
                  res_status_in = mids_pkg::ST_OK;
                  res_prior_in  = mids_pkg::CELL_UNSEEN;
                  state_in      = S_RESP;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = mids_pkg::CELL_UNSEEN;
               end
            end
         end

         S_CLEAR: begin
            // full clear on a large jump, target written as received
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = (clr_idx_ff == id_idx) ? mids_pkg::CELL_RECEIVED
                                                : mids_pkg::CELL_UNSEEN;
            clr_idx_in = clr_idx_ff + mids_pkg::idx_type'(1);
            if (clr_idx_ff == mids_pkg::LAST_IDX) begin
               commit        = 1'b1;
               act_cnt_in    = mids_pkg::cnt_type'(1);
               res_status_in = mids_pkg::ST_OK;
               res_prior_in  = mids_pkg::CELL_UNSEEN;
               state_in      = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_flag_in   = res_flag_ff;
               rsp_prior_in  = res_prior_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_idx_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         act_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         chk_vld_ff   <= chk_vld_in;
         act_cnt_ff   <= act_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      async_ff      <= async_in;
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      res_status_ff <= res_status_in;
      res_flag_ff   <= res_flag_in;
      res_prior_ff  <= res_prior_in;
      rsp_status_ff <= rsp_status_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_prior_ff  <= rsp_prior_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_flag        = rsp_flag_ff;
   assign rsp_prior_state = rsp_prior_ff;

   // active cell count never exceeds the store
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      act_cnt_ff <= mids_pkg::cnt_type'(mids_pkg::SIZE))
      else $error("active cell count out of range");

   // walk never writes the cell it reads in the same cycle
   a_walk_no_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && wr_en) |-> (wr_addr != rd_addr))
      else $error("walk read and write collide");

   // the window top moves only at the end of a walk or a full clear
   a_commit_src: assert property (@(posedge clock) disable iff (reset)
      commit |-> (state_ff == S_WALK || state_ff == S_CLEAR))
      else $error("window top moved outside an advance");

   // rejected ids carry no prior state
   a_reject_prior: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == mids_pkg::ST_TOO_LOW ||
                     rsp_status == mids_pkg::ST_TOO_HIGH ||
                     rsp_status == mids_pkg::ST_OUTSIDE))
      |-> (rsp_prior_state == mids_pkg::CELL_UNSEEN))
      else $error("prior state reported for a rejected id");

   // an item is taken only after the previous result was loaded
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DECODE))
      else $error("accepted item did not enter decode");

endmodule
